// ===== src/fpa_pkg.sv =====
package fpa_pkg;

    // Default number of fraction bits in a raw word.
    localparam int FPA_FRACTION_BITS = 8;

    // Cycles through the multiplier from its registered operands.
    localparam int FPA_MUL_LATENCY = 2;

    // Operation codes.
    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_MIN   = 4'd4,
        OP_MAX   = 4'd5,
        OP_INC   = 4'd6,
        OP_DEC   = 4'd7,
        OP_TOINT = 4'd8
    } t_op;

    // Source of the final result.
    typedef enum logic [1:0] {
        SEL_SIDE = 2'd0,
        SEL_MUL  = 2'd1,
        SEL_DIV  = 2'd2
    } t_sel;

    // Per-word information that travels beside the arithmetic units.
    typedef struct packed {
        logic        valid;
        t_sel        sel;
        logic        neg;
        logic [31:0] res;
        logic        ovf;
        logic        dz;
        logic        gt;
        logic        lt;
        logic        eq;
    } t_side;

    // Divider latency: one load stage, one stage per quotient bit, one rounding stage.
    function automatic int fpa_div_latency(input int frac_bits);
        return 32 + frac_bits + 2;
    endfunction

endpackage

// ===== src/fixed_point_alu_core.sv =====
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_operation, i_operand_a, i_operand_b
// result    out        o_valid / i_stall  o_result_raw, o_a_greater, o_a_less,
//                                          o_a_equal, o_overflow, o_divide_by_zero
//
// One word is accepted per cycle while o_stall is low.
// The divider, which resolves one quotient bit per stage, sets the depth of the pipeline.
// Reset clears the valid bits of every stage and the skid register.
// The whole pipeline advances when the output register is empty or taken; one
// skid register catches a word that arrives while the pipeline is held.
module fixed_point_alu_core #(
    parameter int FRACTION_BITS = fpa_pkg::FPA_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_operation,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_result_raw,
    output logic        o_a_greater,
    output logic        o_a_less,
    output logic        o_a_equal,
    output logic        o_overflow,
    output logic        o_divide_by_zero
);
    import fpa_pkg::*;

    localparam int DL  = fpa_div_latency(FRACTION_BITS);
    localparam int PAD = DL - FPA_MUL_LATENCY;

    logic        w_en;
    logic        r_skid_full;
    logic [3:0]  r_skid_op;
    logic [31:0] r_skid_a;
    logic [31:0] r_skid_b;
    logic        r_s0_valid;
    logic [3:0]  r_s0_op;
    logic [31:0] r_s0_a;
    logic [31:0] r_s0_b;
    t_side       n_side;
    t_side       r_side;
    logic [31:0] r_ma;
    logic [31:0] r_mb;
    t_side       r_line [DL];
    logic [63:0] w_mul_mag;
    logic [63:0] w_div_mag;
    logic [63:0] r_mpad [PAD];
    logic        r_out_valid;
    logic [31:0] r_out_res;
    logic        r_out_ovf;
    logic        r_out_dz;
    logic        r_out_gt;
    logic        r_out_lt;
    logic        r_out_eq;
    logic [63:0] w_mag;
    logic [31:0] w_res;
    logic        w_ovf;

    // Global advance: the output register is free or its word is taken.
    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = r_skid_full;

    // Skid register and entry stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
            r_s0_valid  <= 1'b0;
        end else if (w_en) begin
            r_skid_full <= 1'b0;
            r_s0_valid  <= r_skid_full || i_valid;
        end else if (i_valid && !r_skid_full) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_op <= r_skid_full ? r_skid_op : i_operation;
            r_s0_a  <= r_skid_full ? r_skid_a  : i_operand_a;
            r_s0_b  <= r_skid_full ? r_skid_b  : i_operand_b;
        end else if (i_valid && !r_skid_full) begin
            r_skid_op <= i_operation;
            r_skid_a  <= i_operand_a;
            r_skid_b  <= i_operand_b;
        end
    end

    // Simple operations, compare flags and operand magnitudes.
    always_comb begin
        logic signed [32:0] w_sum;
        logic signed [31:0] w_sa;
        logic signed [31:0] w_sb;
        w_sa  = $signed(r_s0_a);
        w_sb  = $signed(r_s0_b);
        w_sum = '0;
        n_side       = '0;
        n_side.valid = r_s0_valid;
        n_side.sel   = SEL_SIDE;
        n_side.neg   = r_s0_a[31] ^ r_s0_b[31];
        n_side.gt    = w_sa > w_sb;
        n_side.lt    = w_sa < w_sb;
        n_side.eq    = r_s0_a == r_s0_b;
        case (r_s0_op) inside
            OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                if (r_s0_op == OP_ADD) begin
                    w_sum = 33'(w_sa) + 33'(w_sb);
                end else if (r_s0_op == OP_SUB) begin
                    w_sum = 33'(w_sa) - 33'(w_sb);
                end else if (r_s0_op == OP_INC) begin
                    w_sum = 33'(w_sa) + 33'sd1;
                end else begin
                    w_sum = 33'(w_sa) - 33'sd1;
                end
                if (w_sum[32] != w_sum[31]) begin
                    n_side.ovf = 1'b1;
                    n_side.res = w_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    n_side.res = w_sum[31:0];
                end
            end
            OP_MUL: n_side.sel = SEL_MUL;
            OP_DIV: begin
                if (r_s0_b == '0) begin
                    n_side.dz  = 1'b1;
                    n_side.res = r_s0_a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    n_side.sel = SEL_DIV;
                end
            end
            OP_MIN:   n_side.res = (w_sa > w_sb) ? r_s0_b : r_s0_a;
            OP_MAX:   n_side.res = (w_sa > w_sb) ? r_s0_a : r_s0_b;
            OP_TOINT: n_side.res = 32'(w_sa >>> FRACTION_BITS);
            default:  n_side.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (w_en) begin
            r_side <= n_side;
        end
        if (i_rst_n && w_en) begin
            r_ma <= r_s0_a[31] ? 32'(-r_s0_a) : r_s0_a;
            r_mb <= r_s0_b[31] ? 32'(-r_s0_b) : r_s0_b;
        end
    end

    fpa_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_mag_a (r_ma),
        .i_mag_b (r_mb),
        .o_mag   (w_mul_mag)
    );

    fpa_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_mag_a (r_ma),
        .i_mag_b (r_mb),
        .o_mag   (w_div_mag)
    );

    // Side information and product wait for the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DL; i++) begin
                r_line[i].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_line[0] <= r_side;
            for (int i = 1; i < DL; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mpad[0] <= w_mul_mag;
            for (int i = 1; i < PAD; i++) begin
                r_mpad[i] <= r_mpad[i-1];
            end
        end
    end

    // Saturate the unit magnitude by the result sign, or pass the side result through.
    always_comb begin
        w_mag = (r_line[DL-1].sel == SEL_MUL) ? r_mpad[PAD-1] : w_div_mag;
        w_ovf = 1'b0;
        if (r_line[DL-1].neg) begin
            if (w_mag > 64'h8000_0000) begin
                w_ovf = 1'b1;
                w_res = 32'h8000_0000;
            end else begin
                w_res = 32'(64'd0 - w_mag);
            end
        end else if (w_mag > 64'h7FFF_FFFF) begin
            w_ovf = 1'b1;
            w_res = 32'h7FFF_FFFF;
        end else begin
            w_res = w_mag[31:0];
        end
        if (r_line[DL-1].sel == SEL_SIDE) begin
            w_res = r_line[DL-1].res;
            w_ovf = r_line[DL-1].ovf;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_line[DL-1].valid;
        end
        if (i_rst_n && w_en) begin
            r_out_res <= w_res;
            r_out_ovf <= w_ovf;
            r_out_dz  <= r_line[DL-1].dz;
            r_out_gt  <= r_line[DL-1].gt;
            r_out_lt  <= r_line[DL-1].lt;
            r_out_eq  <= r_line[DL-1].eq;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_raw     = r_out_res;
    assign o_overflow       = r_out_ovf;
    assign o_divide_by_zero = r_out_dz;
    assign o_a_greater      = r_out_gt;
    assign o_a_less         = r_out_lt;
    assign o_a_equal        = r_out_eq;

    // A zero divisor saturates without reporting overflow.
    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> !o_overflow)
        else $error("divide by zero word also flags overflow");

    // Exactly one compare relation holds for every word.
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_a_greater, o_a_less, o_a_equal}))
        else $error("compare flags are not one-hot");

    // The skid register fills only while the pipeline is held.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_full) |-> $past(!w_en))
        else $error("skid register filled while pipeline advanced");

endmodule

// ===== src/fpa_mul.sv =====
module fpa_mul #(
    parameter int FRACTION_BITS = fpa_pkg::FPA_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_mag_a,
    input  logic [31:0] i_mag_b,
    output logic [63:0] o_mag
);
    import fpa_pkg::*;

    // Half of one raw step, zero when there are no fraction bits.
    localparam logic [63:0] HALF = (64'd1 << FRACTION_BITS) >> 1;

    logic [63:0] r_prod;
    logic [63:0] r_mag;

    // Stage one is the product, stage two rounds half away from zero on the magnitude.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_mag_a * i_mag_b;
            r_mag  <= (r_prod + HALF) >> FRACTION_BITS;
        end
    end

    assign o_mag = r_mag;

endmodule

// ===== src/fpa_div.sv =====
module fpa_div #(
    parameter int FRACTION_BITS = fpa_pkg::FPA_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_mag_a,
    input  logic [31:0] i_mag_b,
    output logic [63:0] o_mag
);
    import fpa_pkg::*;

    // Quotient width: the dividend is the magnitude shifted up by the fraction bits.
    localparam int QW = 32 + FRACTION_BITS;

    logic [QW-1:0] r_num [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic [31:0]   r_rem [QW+1];
    logic [31:0]   r_div [QW+1];
    logic [63:0]   r_mag;

    // Load stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= QW'(i_mag_a) << FRACTION_BITS;
            r_quo[0] <= '0;
            r_rem[0] <= '0;
            r_div[0] <= i_mag_b;
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [32:0]   w_trial;
        logic [31:0]   n_rem;
        logic [QW-1:0] n_quo;

        always_comb begin
            w_trial = {r_rem[k], r_num[k][QW-1-k]};
            n_rem   = w_trial[31:0];
            n_quo   = r_quo[k];
            if (w_trial >= {1'b0, r_div[k]}) begin
                n_rem           = 32'(w_trial - {1'b0, r_div[k]});
                n_quo[QW-1-k]   = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k+1] <= r_num[k];
                r_quo[k+1] <= n_quo;
                r_rem[k+1] <= n_rem;
                r_div[k+1] <= r_div[k];
            end
        end
    end

    // Round half away from zero: bump when twice the remainder reaches the divisor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= 64'(r_quo[QW])
                   + 64'({r_rem[QW], 1'b0} >= {1'b0, r_div[QW]});
        end
    end

    assign o_mag = r_mag;

endmodule
